FILE: design/exlex_pkg.sv
package exlex_pkg;

  localparam int unsigned MaxTokenLen = 64;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoAw      = $clog2(FifoDepth);

  localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNl      = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChLparen  = 8'h28;
  localparam logic [7:0] ChRparen  = 8'h29;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChLess    = 8'h3C;
  localparam logic [7:0] ChEqual   = 8'h3D;
  localparam logic [7:0] ChGreater = 8'h3E;

  localparam logic [63:0] WordIf   = 64'h6669;
  localparam logic [63:0] WordElse = 64'h6573_6C65;
  localparam logic [63:0] WordThen = 64'h6E65_6874;
  localparam logic [63:0] WordEnd  = 64'h64_6E65;

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_NUM     = 3'd1,
    ST_ID      = 3'd2,
    ST_LESS    = 3'd3,
    ST_ASSIGN  = 3'd4,
    ST_GREATER = 3'd5,
    ST_STRING  = 3'd6,
    ST_COMMENT = 3'd7
  } scan_e;

  typedef enum logic [4:0] {
    K_BAD     = 5'd0,
    K_PLUS    = 5'd1,
    K_MINUS   = 5'd2,
    K_MUL     = 5'd3,
    K_DIV     = 5'd4,
    K_LPAREN  = 5'd5,
    K_RPAREN  = 5'd6,
    K_SEMI    = 5'd7,
    K_ASSIGN  = 5'd8,
    K_EQ      = 5'd9,
    K_LT      = 5'd10,
    K_LE      = 5'd11,
    K_GT      = 5'd12,
    K_GE      = 5'd13,
    K_NUMBER  = 5'd14,
    K_STRING  = 5'd15,
    K_IDENT   = 5'd16,
    K_IF      = 5'd17,
    K_ELSE    = 5'd18,
    K_THEN    = 5'd19,
    K_END     = 5'd20,
    K_TOOLONG = 5'd21,
    K_EOF     = 5'd22
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  len;
    logic [63:0] prefix;
    logic [30:0] num;
    logic        last;
  } result_t;

  typedef struct packed {
    scan_e       st;
    logic [6:0]  cnt;
    logic [63:0] bytes;
    logic [30:0] acc;
    logic        emit;
    kind_e       kind;
  } start_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic kind_e word_kind(logic [6:0] cnt, logic [63:0] bytes);
    kind_e k;
    k = K_IDENT;
    if (cnt == 7'd2 && bytes == WordIf) k = K_IF;
    else if (cnt == 7'd4 && bytes == WordElse) k = K_ELSE;
    else if (cnt == 7'd4 && bytes == WordThen) k = K_THEN;
    else if (cnt == 7'd3 && bytes == WordEnd) k = K_END;
    return k;
  endfunction

  // Scan of one byte from a cleared start state.
  function automatic start_t start_char(logic [7:0] c);
    start_t s;
    s      = '0;
    s.st   = ST_START;
    s.kind = K_BAD;
    if (c == ChSpace || c == ChTab || c == ChNl) begin
      s.emit = 1'b0;
    end else if (is_digit(c)) begin
      s.cnt   = 7'd1;
      s.bytes = {56'd0, c};
      s.acc   = {27'd0, 4'(c - ChZero)};
      s.st    = ST_NUM;
    end else if (is_alpha(c)) begin
      s.cnt   = 7'd1;
      s.bytes = {56'd0, c};
      s.st    = ST_ID;
    end else if (c == ChLess || c == ChEqual || c == ChGreater) begin
      s.cnt   = 7'd1;
      s.bytes = {56'd0, c};
      s.st    = (c == ChLess) ? ST_LESS : ((c == ChEqual) ? ST_ASSIGN : ST_GREATER);
    end else if (c == ChQuote) begin
      s.st = ST_STRING;
    end else if (c == ChHash) begin
      s.st = ST_COMMENT;
    end else begin
      s.emit = 1'b1;
      case (c)
        ChPlus:   s.kind = K_PLUS;
        ChMinus:  s.kind = K_MINUS;
        ChStar:   s.kind = K_MUL;
        ChSlash:  s.kind = K_DIV;
        ChLparen: s.kind = K_LPAREN;
        ChRparen: s.kind = K_RPAREN;
        ChSemi:   s.kind = K_SEMI;
        default:  s.kind = K_BAD;
      endcase
    end
    return s;
  endfunction

endpackage

FILE: design/expression_language_lexer.sv
// Byte-serial lexer: takes one character beat per cycle while the result
// queue has room and returns tokens (operators, comparisons, numbers
// saturated at 2147483647, identifiers, keywords, strings, too-long and eof
// markers). A byte goes through an input register, then a single pass of
// scan logic against the held token state, and the tokens it yields, up to
// two, land in a four-entry result queue. The scan stage advances whenever
// the queue has room for two tokens, so with a consumer that takes one
// token per cycle the block sustains one byte per cycle, less where a byte
// closes a token and starts another. last_of_run marks the final token of
// a byte.
module expression_language_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [6:0]  text_length_o,
  output logic [63:0] text_prefix_o,
  output logic [30:0] number_value_o,
  output logic        last_of_run_o
);

  localparam logic [6:0] MaxLen = 7'(exlex_pkg::MaxTokenLen);
  localparam int unsigned Aw = exlex_pkg::FifoAw;

  logic                     s_valid_q;
  logic [7:0]               ch_q;
  logic                     eoi_q;
  logic                     fire;

  exlex_pkg::scan_e         st_q, st_d;
  logic [6:0]               cnt_q, cnt_d;
  logic [63:0]              bytes_q, bytes_d;
  logic [30:0]              acc_q, acc_d;

  exlex_pkg::result_t       res0, res1;
  logic [1:0]               nres;

  exlex_pkg::result_t       fifo_q [exlex_pkg::FifoDepth];
  logic [Aw-1:0]            head_q, tail_q;
  logic [Aw:0]              fcnt_q;
  logic                     pop;

  // scan logic
  logic                     full;
  logic [63:0]              app_bytes;
  logic [34:0]              acc_x10;
  logic                     rescan;
  exlex_pkg::start_t        sc;
  exlex_pkg::result_t       sres;

  assign full = cnt_q >= MaxLen;
  assign app_bytes = (cnt_q < 7'd8) ? (bytes_q | ({56'd0, ch_q} << {cnt_q[2:0], 3'b000}))
                                    : bytes_q;
  assign acc_x10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
                 + {31'd0, 4'(ch_q - exlex_pkg::ChZero)};
  assign sc = exlex_pkg::start_char(ch_q);

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    acc_d   = acc_q;
    res0    = '0;
    res1    = '0;
    res0.kind = exlex_pkg::K_BAD;
    res1.kind = exlex_pkg::K_BAD;
    nres    = 2'd0;
    rescan  = 1'b0;
    sres    = '0;
    sres.kind = sc.kind;
    sres.len  = 7'd1;
    sres.prefix = {56'd0, ch_q};
    if (eoi_q) begin
      st_d = exlex_pkg::ST_START; cnt_d = '0; bytes_d = '0; acc_d = '0;
      res0.kind = exlex_pkg::K_EOF;
      nres = 2'd1;
    end else begin
      unique case (st_q)
        exlex_pkg::ST_NUM, exlex_pkg::ST_ID: begin
          if (exlex_pkg::is_digit(ch_q) ||
              (st_q == exlex_pkg::ST_ID && exlex_pkg::is_alpha(ch_q))) begin
            if (full) begin
              st_d = exlex_pkg::ST_START; cnt_d = '0; bytes_d = '0; acc_d = '0;
              res0.kind = exlex_pkg::K_TOOLONG;
              nres = 2'd1;
            end else begin
              cnt_d   = cnt_q + 7'd1;
              bytes_d = app_bytes;
              if (st_q == exlex_pkg::ST_NUM)
                acc_d = (acc_x10 > {4'd0, exlex_pkg::NumMax}) ? exlex_pkg::NumMax
                                                               : acc_x10[30:0];
            end
          end else begin
            res0.kind   = (st_q == exlex_pkg::ST_NUM) ? exlex_pkg::K_NUMBER
                                                      : exlex_pkg::word_kind(cnt_q, bytes_q);
            res0.len    = cnt_q;
            res0.prefix = bytes_q;
            res0.num    = (st_q == exlex_pkg::ST_NUM) ? acc_q : '0;
            nres   = 2'd1;
            rescan = 1'b1;
          end
        end
        exlex_pkg::ST_LESS, exlex_pkg::ST_ASSIGN, exlex_pkg::ST_GREATER: begin
          if (ch_q == exlex_pkg::ChEqual) begin
            res0.kind = (st_q == exlex_pkg::ST_LESS) ? exlex_pkg::K_LE :
                        (st_q == exlex_pkg::ST_ASSIGN) ? exlex_pkg::K_EQ : exlex_pkg::K_GE;
            res0.len    = cnt_q + 7'd1;
            res0.prefix = app_bytes;
            nres = 2'd1;
            st_d = exlex_pkg::ST_START; cnt_d = '0; bytes_d = '0; acc_d = '0;
          end else begin
            res0.kind = (st_q == exlex_pkg::ST_LESS) ? exlex_pkg::K_LT :
                        (st_q == exlex_pkg::ST_ASSIGN) ? exlex_pkg::K_ASSIGN : exlex_pkg::K_GT;
            res0.len    = cnt_q;
            res0.prefix = bytes_q;
            nres   = 2'd1;
            rescan = 1'b1;
          end
        end
        exlex_pkg::ST_STRING: begin
          if (ch_q == exlex_pkg::ChQuote) begin
            res0.kind   = exlex_pkg::K_STRING;
            res0.len    = cnt_q;
            res0.prefix = bytes_q;
            nres = 2'd1;
            st_d = exlex_pkg::ST_START; cnt_d = '0; bytes_d = '0; acc_d = '0;
          end else if (full) begin
            res0.kind = exlex_pkg::K_TOOLONG;
            nres = 2'd1;
            st_d = exlex_pkg::ST_START; cnt_d = '0; bytes_d = '0; acc_d = '0;
          end else begin
            cnt_d   = cnt_q + 7'd1;
            bytes_d = app_bytes;
          end
        end
        exlex_pkg::ST_COMMENT: begin
          if (ch_q == exlex_pkg::ChNl) begin
            st_d = exlex_pkg::ST_START; cnt_d = '0; bytes_d = '0; acc_d = '0;
          end
        end
        exlex_pkg::ST_START: begin
          rescan = 1'b1;
        end
        default: begin
          rescan = 1'b1;
        end
      endcase
      if (rescan) begin
        st_d    = sc.st;
        cnt_d   = sc.cnt;
        bytes_d = sc.bytes;
        acc_d   = sc.acc;
        if (sc.emit) begin
          if (nres == 2'd1) begin
            res1 = sres;
            nres = 2'd2;
          end else begin
            res0 = sres;
            nres = 2'd1;
          end
        end
      end
      if (nres == 2'd2) res1.last = 1'b1;
      else if (nres == 2'd1) res0.last = 1'b1;
    end
    if (eoi_q) res0.last = 1'b1;
  end

  // handshake
  assign fire       = s_valid_q && (fcnt_q <= (Aw+1)'(exlex_pkg::FifoDepth - 2));
  assign in_ready_o = !s_valid_q || fire;
  assign pop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q  <= ch_i;
      eoi_q <= end_of_input_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= exlex_pkg::ST_START;
      cnt_q   <= '0;
      bytes_q <= '0;
      acc_q   <= '0;
    end else if (fire) begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
      acc_q   <= acc_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fcnt_q <= '0;
    end else begin
      if (pop) head_q <= head_q + Aw'(1);
      if (fire) tail_q <= tail_q + Aw'(nres);
      fcnt_q <= fcnt_q - (Aw+1)'(pop) + (fire ? (Aw+1)'(nres) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && nres != 2'd0) fifo_q[tail_q] <= res0;
    if (fire && nres == 2'd2) fifo_q[tail_q + Aw'(1)] <= res1;
  end

  assign out_valid_o    = fcnt_q != '0;
  assign token_kind_o   = fifo_q[head_q].kind;
  assign text_length_o  = fifo_q[head_q].len;
  assign text_prefix_o  = fifo_q[head_q].prefix;
  assign number_value_o = fifo_q[head_q].num;
  assign last_of_run_o  = fifo_q[head_q].last;

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= (Aw+1)'(exlex_pkg::FifoDepth))
    else $error("result queue overflow");

  a_fire_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> fcnt_q <= (Aw+1)'(exlex_pkg::FifoDepth - 2))
    else $error("scan stage advanced without queue room");

  a_pair_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> fcnt_q >= (Aw+1)'(2))
    else $error("first token of a pair shown without its partner");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o == exlex_pkg::K_EOF) |-> last_of_run_o)
    else $error("eof token not marked last");

  a_num_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o != exlex_pkg::K_NUMBER) |-> number_value_o == '0)
    else $error("number value on a non-number token");

endmodule

FILE: tb/sv/token_check_pkg.sv
`timescale 1ns / 1ps

package token_check_pkg;
  import exlex_pkg::*;

  class token_tracker;
    scan_e       st;
    logic [6:0]  held_len;
    logic [63:0] held_text;
    logic [30:0] value;
    result_t     pending[$];
    int unsigned faults;

    function new();
      drop_token();
      faults = 0;
    endfunction

    function void drop_token();
      st        = ST_START;
      held_len  = '0;
      held_text = '0;
      value     = '0;
    endfunction

    function bit numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function void push_token(kind_e k, logic [6:0] len, logic [63:0] text, logic [30:0] num);
      result_t r;
      r.kind   = k;
      r.len    = len;
      r.prefix = text;
      r.num    = num;
      r.last   = 1'b0;
      pending.push_back(r);
    endfunction

    function void push_held(kind_e k, logic [30:0] num);
      push_token(k, held_len, held_text, num);
    endfunction

    // false when the token already holds the maximum length
    function bit store(logic [7:0] c);
      if (held_len >= MaxTokenLen) return 1'b0;
      if (held_len < 8) held_text[held_len*8 +: 8] = c;
      held_len++;
      return 1'b1;
    endfunction

    function void too_long();
      push_token(K_TOOLONG, '0, '0, '0);
      drop_token();
    endfunction

    function kind_e word_of();
      if (held_len == 7'd2 && held_text == 64'h6669) return K_IF;
      if (held_len == 7'd4 && held_text == 64'h6573_6C65) return K_ELSE;
      if (held_len == 7'd4 && held_text == 64'h6E65_6874) return K_THEN;
      if (held_len == 7'd3 && held_text == 64'h64_6E65) return K_END;
      return K_IDENT;
    endfunction

    function void open_token(logic [7:0] c);
      kind_e k;
      drop_token();
      if (c == ChSpace || c == ChTab || c == ChNl) return;
      if (numeral(c)) begin
        void'(store(c));
        value = 31'(c - ChZero);
        st    = ST_NUM;
      end else if (letter(c)) begin
        void'(store(c));
        st = ST_ID;
      end else if (c == ChLess) begin
        void'(store(c));
        st = ST_LESS;
      end else if (c == ChEqual) begin
        void'(store(c));
        st = ST_ASSIGN;
      end else if (c == ChGreater) begin
        void'(store(c));
        st = ST_GREATER;
      end else if (c == ChQuote) begin
        st = ST_STRING;
      end else if (c == ChHash) begin
        st = ST_COMMENT;
      end else begin
        case (c)
          ChPlus:   k = K_PLUS;
          ChMinus:  k = K_MINUS;
          ChStar:   k = K_MUL;
          ChSlash:  k = K_DIV;
          ChLparen: k = K_LPAREN;
          ChRparen: k = K_RPAREN;
          ChSemi:   k = K_SEMI;
          default:  k = K_BAD;
        endcase
        push_token(k, 7'd1, {56'd0, c}, '0);
      end
    endfunction

    function void take_byte(logic [7:0] c, logic eoi);
      int unsigned prior_size;
      bit          again;
      kind_e       one;
      kind_e       two;
      logic [63:0] wide;
      result_t     r;
      prior_size = pending.size();
      again      = 1'b0;
      if (eoi) begin
        drop_token();
        push_token(K_EOF, '0, '0, '0);
      end else begin
        case (st)
          ST_NUM: begin
            if (numeral(c)) begin
              if (!store(c)) begin
                too_long();
              end else begin
                wide  = 64'(value) * 64'd10 + 64'(c - ChZero);
                value = (wide > 64'(NumMax)) ? NumMax : wide[30:0];
              end
            end else begin
              push_held(K_NUMBER, value);
              again = 1'b1;
            end
          end
          ST_ID: begin
            if (numeral(c) || letter(c)) begin
              if (!store(c)) too_long();
            end else begin
              push_held(word_of(), '0);
              again = 1'b1;
            end
          end
          ST_LESS, ST_ASSIGN, ST_GREATER: begin
            case (st)
              ST_LESS: begin
                one = K_LT;
                two = K_LE;
              end
              ST_ASSIGN: begin
                one = K_ASSIGN;
                two = K_EQ;
              end
              default: begin
                one = K_GT;
                two = K_GE;
              end
            endcase
            if (c == ChEqual) begin
              void'(store(c));
              push_held(two, '0);
              drop_token();
            end else begin
              push_held(one, '0);
              again = 1'b1;
            end
          end
          ST_STRING: begin
            if (c == ChQuote) begin
              push_held(K_STRING, '0);
              drop_token();
            end else if (!store(c)) begin
              too_long();
            end
          end
          ST_COMMENT: begin
            if (c == ChNl) drop_token();
          end
          default: open_token(c);
        endcase
        if (again) open_token(c);
      end
      if (pending.size() > prior_size) begin
        r      = pending.pop_back();
        r.last = 1'b1;
        pending.push_back(r);
      end
    endfunction

    function void match_token(logic [4:0] kind, logic [6:0] len, logic [63:0] text,
                              logic [30:0] num, logic last);
      result_t want;
      if (pending.size() == 0) begin
        $error("token with none expected: token_kind %0d", kind);
        faults++;
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, kind);
        faults++;
      end
      if (len !== want.len) begin
        $error("text_length: expected %0d, got %0d", want.len, len);
        faults++;
      end
      if (text !== want.prefix) begin
        $error("text_prefix: expected %h, got %h", want.prefix, text);
        faults++;
      end
      if (num !== want.num) begin
        $error("number_value: expected %0d, got %0d", want.num, num);
        faults++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, last);
        faults++;
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import exlex_pkg::*;
  import token_check_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned Settle     = 8;
  localparam int unsigned PhaseItems = 184;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  ch           = '0;
  logic        end_of_input = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [4:0]  token_kind;
  logic [6:0]  text_length;
  logic [63:0] text_prefix;
  logic [30:0] number_value;
  logic        last_of_run;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned sent          = 0;

  token_tracker tracker = new();

  expression_language_lexer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .ch_i           (ch),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind),
    .text_length_o  (text_length),
    .text_prefix_o  (text_prefix),
    .number_value_o (number_value),
    .last_of_run_o  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_byte(ch, end_of_input);
      if (out_valid && out_ready) begin
        tracker.match_token(token_kind, text_length, text_prefix, number_value, last_of_run);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (rst_n);
    while (quiet_cycles < StallLimit) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] alpha_byte();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'(ChZero + $urandom_range(9));
  endfunction

  // mostly short, now and then right around the length limit
  function automatic int unsigned pick_len(int unsigned typical);
    if ($urandom_range(49) == 0) return MaxTokenLen - 1 + $urandom_range(3);
    return $urandom_range(1, typical);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    ch           <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic send_lexeme();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  c;
    string       word;
    pick = $urandom_range(99);
    if (pick < 18) begin
      n = pick_len(8);
      send_byte(alpha_byte(), 1'b0);
      repeat (n - 1) send_byte($urandom_range(1) ? alpha_byte() : digit_byte(), 1'b0);
      sent += n;
    end else if (pick < 24) begin
      case ($urandom_range(7))
        0: word = "if";
        1: word = "else";
        2: word = "then";
        3: word = "end";
        4: word = "iff";
        5: word = "els";
        6: word = "ende";
        default: word = "Then";
      endcase
      send_text(word);
      sent += word.len();
    end else if (pick < 38) begin
      n = pick_len(($urandom_range(3) == 0) ? 13 : 4);
      repeat (n) send_byte(digit_byte(), 1'b0);
      sent += n;
    end else if (pick < 46) begin
      n = ($urandom_range(9) == 0) ? 0 : pick_len(10);
      send_byte(ChQuote, 1'b0);
      repeat (n) begin
        c = 8'($urandom_range(255));
        if (c == ChQuote) c = ChNl;
        send_byte(c, 1'b0);
      end
      if ($urandom_range(9) != 0) begin
        send_byte(ChQuote, 1'b0);
        sent++;
      end
      sent += n + 1;
    end else if (pick < 51) begin
      n = $urandom_range(6);
      send_byte(ChHash, 1'b0);
      repeat (n) begin
        c = 8'($urandom_range(255));
        if (c == ChNl) c = ChSpace;
        send_byte(c, 1'b0);
      end
      send_byte(ChNl, 1'b0);
      sent += n + 2;
    end else if (pick < 64) begin
      word = "+-*/();";
      send_byte(word[$urandom_range(6)], 1'b0);
      sent++;
    end else if (pick < 78) begin
      case ($urandom_range(5))
        0: word = "<";
        1: word = "<=";
        2: word = ">";
        3: word = ">=";
        4: word = "=";
        default: word = "==";
      endcase
      send_text(word);
      sent += word.len();
    end else if (pick < 89) begin
      case ($urandom_range(2))
        0: send_byte(ChSpace, 1'b0);
        1: send_byte(ChTab, 1'b0);
        default: send_byte(ChNl, 1'b0);
      endcase
      sent++;
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(255)), 1'b0);
      sent++;
    end else begin
      send_byte(8'($urandom_range(255)), 1'b1);
      sent++;
    end
  endtask

  initial begin
    bit held;
    held          = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 71;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("+-*/();<=>=<a>1===\"q\n\"");
    send_byte(8'h5A, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        send_lexeme();
        // sink stalls while bytes keep coming, to back up the result queue
        if (phase == 2 && !held && sent > 60) begin
          recv_hold = 60;
          held      = 1'b1;
        end
      end
      drain();
    end

    if (tracker.faults == 0 && tracker.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
